@@ rtl/linear_probe_hash_table_macros.svh @@
// assertion macros for the linear probe hash table
// expects clk and rst in the scope of the module that uses them
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define LPHT_ASSERT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LPHT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/lpht_pkg.sv @@
// shared types, constants and the home slot table of the hash table
// no dependencies
package lpht_pkg;

  localparam int SLOTS   = 7;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int KEY_W   = 7;
  localparam int VAL_W   = 32;
  localparam int KEY_NUM = 1 << KEY_W;
  localparam int KEY_LIMIT = 99;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_KEY   = 2'd3;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic empty;
    logic hit;
    logic last;
  } probe_flags_t;

  typedef logic [IDX_W-1:0] home_tab_t [KEY_NUM];

  function automatic home_tab_t build_home_tab();
    home_tab_t tab;
    for (int k = 0; k < KEY_NUM; k++) begin
      tab[k] = IDX_W'((k * k + k) % SLOTS);
    end
    return tab;
  endfunction

  localparam home_tab_t HOME_TAB = build_home_tab();

endpackage

@@ rtl/lpht_if.sv @@
// request and response channel interfaces of the hash table
// depends on lpht_pkg
interface lpht_req_if import lpht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink (input valid, operation, key, value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic signed [VAL_W-1:0] result_value;
  logic [1:0]       status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

@@ rtl/lpht_slot_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module lpht_slot_ram #(
  parameter int DEPTH = 7,
  parameter int WIDTH = 41,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/lpht_probe_unit.sv @@
// shared probe compare and wrap-around increment
// depends on lpht_pkg
module lpht_probe_unit import lpht_pkg::*; (
  input  logic [1:0]       mark,
  input  logic [KEY_W-1:0] slot_key,
  input  logic [KEY_W-1:0] key,
  input  logic [IDX_W-1:0] pos,
  input  logic [CNT_W-1:0] cnt,
  output probe_flags_t     flags,
  output logic [IDX_W-1:0] pos_inc
);

  always_comb begin
    flags.empty = (mark == MARK_EMPTY);
    flags.hit   = (mark == MARK_USED) && (slot_key == key);
    flags.last  = (cnt == CNT_W'(SLOTS - 1));
    pos_inc     = (pos == IDX_W'(SLOTS - 1)) ? '0 : pos + IDX_W'(1);
  end

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// linear probe hash table: sequencer, slot valid bits and response register
// depends on lpht_pkg, lpht_if, lpht_slot_ram, lpht_probe_unit and the macro header
//
// Usage:
//   req carries operation (insert, lookup, remove), a 7-bit key and a 32-bit
//   value; rsp returns result_value and status, one response per request.
//   req.ready is high only while the sequencer is idle; a request is taken on
//   a cycle with req.valid and req.ready both high.
//   Each request walks the slots from the key's home slot, one slot per cycle
//   through the shared probe unit and the slot ram read port, visiting at most
//   SLOTS slots; a bad key or bad operation skips the walk. The sequencer goes
//   back to idle when the response is loaded, and the next request can be taken
//   in the cycle after that, at the earliest.
//   The response sits in an output register; the walk of the next request
//   runs while it waits, and only loading a new response waits for rsp.ready.
//   Reset clears the per-slot valid bits, so every slot reads as empty at
//   once; no clearing pass is needed, and the response register is emptied.
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table import lpht_pkg::*; (
  input logic       clk,
  input logic       rst,
  lpht_req_if.sink  req,
  lpht_rsp_if.source rsp
);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_DONE} state_t;

  state_t             state;
  logic [1:0]         op_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   value_q;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   cnt;
  logic [SLOTS-1:0]   valid;
  logic [VAL_W-1:0]   res_value;
  logic [1:0]         res_status;
  logic               out_valid;
  logic [VAL_W-1:0]   out_value;
  logic [1:0]         out_status;

  logic               bad_req;
  logic               out_load;
  logic               wr_en;
  slot_entry_t        wr_data;
  slot_entry_t        rd_q;
  logic [IDX_W-1:0]   rd_addr;
  logic [1:0]         cur_mark;
  probe_flags_t       pf;
  logic [IDX_W-1:0]   pos_inc;

  lpht_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  lpht_probe_unit u_probe (
    .mark     (cur_mark),
    .slot_key (rd_q.key),
    .key      (key_q),
    .pos      (pos),
    .cnt      (cnt),
    .flags    (pf),
    .pos_inc  (pos_inc)
  );

  assign cur_mark = valid[pos] ? rd_q.mark : MARK_EMPTY;
  assign bad_req  = (req.operation == OP_INVALID) || (req.key > KEY_W'(KEY_LIMIT));
  assign rd_addr  = (state == S_IDLE) ? HOME_TAB[req.key] : pos_inc;
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    wr_en = 1'b0;
    wr_data = '{mark: MARK_USED, key: key_q, value: value_q};
    if (state == S_PROBE) begin
      if (op_q == OP_INSERT) begin
        wr_en = pf.empty;
      end else if (op_q == OP_REMOVE) begin
        wr_en = !pf.empty && pf.hit;
        wr_data = '{mark: MARK_DELETED, key: rd_q.key, value: rd_q.value};
      end
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q      <= req.operation;
            key_q     <= req.key;
            value_q   <= req.value;
            pos       <= HOME_TAB[req.key];
            cnt       <= '0;
            res_value <= '1;
            if (bad_req) begin
              res_status <= ST_BAD_KEY;
              state      <= S_DONE;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (op_q == OP_INSERT) begin
            if (pf.empty) begin
              valid[pos] <= 1'b1;
              res_status <= ST_OK;
              state      <= S_DONE;
            end else if (pf.last) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              pos <= pos_inc;
              cnt <= cnt + CNT_W'(1);
            end
          end else begin
            if (pf.empty) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else if (pf.hit) begin
              if (op_q == OP_LOOKUP) begin
                res_value <= rd_q.value;
              end
              res_status <= ST_OK;
              state      <= S_DONE;
            end else if (pf.last) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else begin
              pos <= pos_inc;
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LPHT_ASSERT(a_cnt_bound, state == S_PROBE, cnt < CNT_W'(SLOTS), "probe count past table size")
  `LPHT_ASSERT_NEXT(a_wr_ends_walk, wr_en, state == S_DONE, "slot write did not end the walk")
  `LPHT_ASSERT_NEXT(a_valid_sticky, 1'b1, (valid & $past(valid)) == $past(valid),
                    "slot valid bit dropped")
  `LPHT_ASSERT(a_fail_value, out_valid && (out_status != ST_OK), out_value == '1,
               "failed response carries a value")

endmodule
